FILE: sv/dic_pkg.sv
// Package: widths and verdict codes for the in-circle classifier.
package dic_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    VERDICT_INSIDE     = 2'd0,
    VERDICT_ON         = 2'd1,
    VERDICT_OUTSIDE    = 2'd2,
    VERDICT_DEGENERATE = 2'd3
  } verdict_t;
endpackage

FILE: sv/dic_diff_stage.sv
// Difference stage: vertex-minus-query and edge deltas, one register stage.
module dic_diff_stage #(
  parameter int unsigned CB = dic_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_in,
  input  logic signed [CB-1:0] ax, ay, bx, by_coord, cx, cy, qx, qy,
  output logic                 vld_r,
  output logic signed [CB:0]   adx_r, ady_r, bdx_r, bdy_r, cdx_r, cdy_r,
  output logic signed [CB:0]   e1x_r, e1y_r, e2x_r, e2y_r
);
  import dic_pkg::*;

  // Advance valid with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  // Capture sign-extended differences
  always_ff @(posedge clk) begin
    if (adv) begin
      adx_r <= (CB+1)'(ax) - (CB+1)'(qx);
      ady_r <= (CB+1)'(ay) - (CB+1)'(qy);
      bdx_r <= (CB+1)'(bx) - (CB+1)'(qx);
      bdy_r <= (CB+1)'(by_coord) - (CB+1)'(qy);
      cdx_r <= (CB+1)'(cx) - (CB+1)'(qx);
      cdy_r <= (CB+1)'(cy) - (CB+1)'(qy);
      e1x_r <= (CB+1)'(bx) - (CB+1)'(ax);
      e1y_r <= (CB+1)'(cy) - (CB+1)'(ay);
      e2x_r <= (CB+1)'(cx) - (CB+1)'(ax);
      e2y_r <= (CB+1)'(by_coord) - (CB+1)'(ay);
    end
  end
endmodule

FILE: sv/dic_prod_stage.sv
// Product stage: squared lengths, 2x2 cross terms and orientation.
module dic_prod_stage #(
  parameter int unsigned CB = dic_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   vld_in,
  input  logic signed [CB:0]     adx, ady, bdx, bdy, cdx, cdy,
  input  logic signed [CB:0]     e1x, e1y, e2x, e2y,
  output logic                   vld_r,
  output logic signed [2*CB+2:0] al_r, bl_r, cl_r,
  output logic signed [2*CB+2:0] ca_r, cb_r, cc_r,
  output logic [1:0]             so_r
);
  import dic_pkg::*;
  localparam int unsigned PW = 2*CB + 3;

  logic signed [PW-1:0] p [12];
  logic signed [PW-1:0] orient;

  // Widen each operand pair before multiplying
  always_comb begin
    p[0]  = PW'(adx) * PW'(adx);
    p[1]  = PW'(ady) * PW'(ady);
    p[2]  = PW'(bdx) * PW'(bdx);
    p[3]  = PW'(bdy) * PW'(bdy);
    p[4]  = PW'(cdx) * PW'(cdx);
    p[5]  = PW'(cdy) * PW'(cdy);
    p[6]  = PW'(bdx) * PW'(cdy);
    p[7]  = PW'(cdx) * PW'(bdy);
    p[8]  = PW'(cdx) * PW'(ady);
    p[9]  = PW'(adx) * PW'(cdy);
    p[10] = PW'(adx) * PW'(bdy);
    p[11] = PW'(bdx) * PW'(ady);
    orient = PW'(e1x) * PW'(e1y) - PW'(e2x) * PW'(e2y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  // Register sums and orientation sign (bit1 negative, bit0 nonzero)
  always_ff @(posedge clk) begin
    if (adv) begin
      al_r <= p[0] + p[1];
      bl_r <= p[2] + p[3];
      cl_r <= p[4] + p[5];
      ca_r <= p[6] - p[7];
      cb_r <= p[8] - p[9];
      cc_r <= p[10] - p[11];
      so_r <= {orient[PW-1], |orient};
    end
  end
endmodule

FILE: sv/dic_det_stage.sv
// Determinant stages: lifted products, then sum and verdict.
module dic_det_stage #(
  parameter int unsigned CB = dic_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   vld_in,
  input  logic signed [2*CB+2:0] al, bl, cl, ca, cb, cc,
  input  logic [1:0]             so,
  output logic                   vld_r,
  output logic [1:0]             verdict_r
);
  import dic_pkg::*;
  localparam int unsigned QW = 4*CB + 6;
  localparam int unsigned DW = QW + 2;

  logic                 v3_r;
  logic signed [QW-1:0] t0_r, t1_r, t2_r;
  logic [1:0]           so3_r;
  logic signed [DW-1:0] det;
  logic                 neg;
  verdict_t             vd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r  <= 1'b0;
      vld_r <= 1'b0;
    end else if (adv) begin
      v3_r  <= vld_in;
      vld_r <= v3_r;
    end
  end

  // Lifted products, one register after the multipliers
  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r  <= QW'(al) * QW'(ca);
      t1_r  <= QW'(bl) * QW'(cb);
      t2_r  <= QW'(cl) * QW'(cc);
      so3_r <= so;
    end
  end

  // Combine signs of determinant and orientation
  always_comb begin
    det = DW'(t0_r) + DW'(t1_r) + DW'(t2_r);
    neg = det[DW-1] ^ so3_r[1];
    if (!so3_r[0]) begin
      vd = VERDICT_DEGENERATE;
    end else if (det == '0) begin
      vd = VERDICT_ON;
    end else if (neg) begin
      vd = VERDICT_OUTSIDE;
    end else begin
      vd = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict_r <= vd;
    end
  end
endmodule

FILE: sv/delaunay_incircle_classifier_core.sv
// In-circle classifier: exact test of a query point against a triangle's
// circumcircle. Takes one transfer per cycle unless stalled; each goes
// through the difference, product, lifted-product and decision stages;
// a stall on the output freezes the whole pipeline, and an empty output slot
// lets new transfers in even while downstream stalls. Verdict: 0 inside,
// 1 on the circle, 2 outside, 3 when the three vertices are collinear.
module delaunay_incircle_classifier_core #(
  parameter int unsigned COORD_BITS = dic_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_ax, in_ay, in_bx, in_by_coord,
  input  logic signed [COORD_BITS-1:0] in_cx, in_cy, in_qx, in_qy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_verdict
);
  import dic_pkg::*;
  localparam int unsigned CB = COORD_BITS;

  logic                   adv, v1, v2;
  logic signed [CB:0]     adx, ady, bdx, bdy, cdx, cdy, e1x, e1y, e2x, e2y;
  logic signed [2*CB+2:0] al, bl, cl, ca, cb, cc;
  logic [1:0]             so;

  // Advance when the output slot is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  dic_diff_stage #(.CB(CB)) u_diff (
    .clk, .rst_n, .adv, .vld_in(in_valid),
    .ax(in_ax), .ay(in_ay), .bx(in_bx), .by_coord(in_by_coord),
    .cx(in_cx), .cy(in_cy), .qx(in_qx), .qy(in_qy),
    .vld_r(v1), .adx_r(adx), .ady_r(ady), .bdx_r(bdx), .bdy_r(bdy),
    .cdx_r(cdx), .cdy_r(cdy), .e1x_r(e1x), .e1y_r(e1y), .e2x_r(e2x), .e2y_r(e2y)
  );

  dic_prod_stage #(.CB(CB)) u_prod (
    .clk, .rst_n, .adv, .vld_in(v1),
    .adx, .ady, .bdx, .bdy, .cdx, .cdy, .e1x, .e1y, .e2x, .e2y,
    .vld_r(v2), .al_r(al), .bl_r(bl), .cl_r(cl),
    .ca_r(ca), .cb_r(cb), .cc_r(cc), .so_r(so)
  );

  dic_det_stage #(.CB(CB)) u_det (
    .clk, .rst_n, .adv, .vld_in(v2),
    .al, .bl, .cl, .ca, .cb, .cc, .so,
    .vld_r(out_valid), .verdict_r(out_verdict)
  );
endmodule

FILE: sv/dic_checker.sv
// Port checker for the in-circle classifier, bound to the top level.
module dic_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_verdict
);
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_verdict))
    else $error("result changed under stall");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");
endmodule

bind delaunay_incircle_classifier_core dic_checker u_dic_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_verdict
);

FILE: test/incircle_checker.sv
// Checker: watches both channels, predicts each verdict and compares it in order.
`timescale 1ns / 1ps
module incircle_checker #(
  parameter int unsigned CB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by_coord,
  input  logic signed [CB-1:0] in_cx, in_cy, in_qx, in_qy,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_verdict,
  output int                   fail_count,
  output int                   pending_count,
  output int                   verdict_seen [4]
);
  import dic_pkg::*;

  verdict_t verdict_q[$];

  // Exact in-circle decision using wide signed integers.
  function automatic verdict_t classify_point(
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy, qx, qy);
    logic signed [159:0] orient, adx, ady, bdx, bdy, cdx, cdy, al, bl, cl, det;
    int so, sd;
    orient = (160'(bx) - ax) * (160'(cy) - ay) - (160'(cx) - ax) * (160'(by) - ay);
    if (orient == 0) return VERDICT_DEGENERATE;
    so = (orient < 0) ? -1 : 1;
    adx = 160'(ax) - qx; ady = 160'(ay) - qy;
    bdx = 160'(bx) - qx; bdy = 160'(by) - qy;
    cdx = 160'(cx) - qx; cdy = 160'(cy) - qy;
    al = adx * adx + ady * ady;
    bl = bdx * bdx + bdy * bdy;
    cl = cdx * cdx + cdy * cdy;
    det = al * (bdx * cdy - cdx * bdy) + bl * (cdx * ady - adx * cdy)
        + cl * (adx * bdy - bdx * ady);
    sd = (det < 0) ? -1 : ((det == 0) ? 0 : 1);
    if (sd * so > 0) return VERDICT_INSIDE;
    if (sd == 0) return VERDICT_ON;
    return VERDICT_OUTSIDE;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    for (int i = 0; i < 4; i++) verdict_seen[i] = 0;
  end

  // Queue predictions on input transfers, compare on output transfers.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && in_valid && !in_stall)
      verdict_q.push_back(classify_point(in_ax, in_ay, in_bx, in_by_coord,
                                         in_cx, in_cy, in_qx, in_qy));
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result transfer with no prediction waiting");
      end else begin
        want = verdict_q.pop_front();
        verdict_seen[want]++;
        if (out_verdict !== want)
          report_mismatch($sformatf("verdict %0d, predicted %0d", out_verdict, want));
      end
    end
    pending_count = verdict_q.size();
  end
endmodule

FILE: test/testbench.sv
// Testbench top: drives point/triangle queries, throttles the output, gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import dic_pkg::*;
  localparam int CB = 16;
  localparam int N_RANDOM = 1100;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by_coord, in_cx, in_cy, in_qx, in_qy;
  logic [1:0] out_verdict;
  int fail_count, pending_count;
  int verdict_seen [4];
  bit hold_long;
  int sent;

  delaunay_incircle_classifier_core #(.COORD_BITS(CB)) dut (.*);
  incircle_checker #(.CB(CB)) u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Small random coordinate, sometimes full range.
  function automatic logic signed [CB-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return CB'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return CB'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // Offer one item and hold it until transferred.
  task automatic send_item(input logic signed [CB-1:0] ax, ay, bx, by, cx, cy, qx, qy);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ax <= ax; in_ay <= ay; in_bx <= bx; in_by_coord <= by;
    in_cx <= cx; in_cy <= cy; in_qx <= qx; in_qy <= qy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Random query; mostly near a random triangle, some on a vertex or collinear.
  task automatic send_random();
    logic signed [CB-1:0] v[8];
    int kind;
    int k;
    for (int i = 0; i < 8; i++) v[i] = pick_coord();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      k = $urandom_range(0, 2);
      v[6] = v[2 * k]; v[7] = v[2 * k + 1];
    end
    if (kind == 1) begin
      v[6] = v[2]; v[7] = v[3];
    end
    if (kind == 2) begin
      v[4] = v[2] + (v[2] - v[0]); v[5] = v[3] + (v[3] - v[1]);
    end
    send_item(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  // Receiver: random stall per result, plus one long hold-off.
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_long = 1'b0;
      end
      w = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int settle;
    rst_n = 1'b0; in_valid = 1'b0; sent = 0; hold_long = 1'b0;
    {in_ax, in_ay, in_bx, in_by_coord, in_cx, in_cy, in_qx, in_qy} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, collinear, coincident, query on vertex, both orientations.
    send_item(0, 0, 10, 0, 0, 10, 1, 1);
    send_item(0, 0, 0, 10, 10, 0, 1, 1);
    send_item(0, 0, 10, 0, 0, 10, 100, 100);
    send_item(0, 0, 10, 0, 0, 10, 10, 10);
    send_item(0, 0, 10, 0, 0, 10, 0, 0);
    send_item(0, 0, 10, 0, 0, 10, 10, 0);
    send_item(0, 0, 5, 5, 10, 10, 3, 4);
    send_item(7, 7, 7, 7, 7, 7, 0, 0);
    send_item(1, 2, 1, 2, 5, 9, 1, 2);
    send_item(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
    send_item(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
    send_item(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
    send_item(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768);
    send_item(-32768, -32768, 32767, 32767, 0, 0, 5, 5);
    send_item(-1, -1, 1, -1, 0, 1, 0, 0);
    send_item(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_item(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh1234, 16'shedcb, 1, -1);

    // Pause until the pipeline drains.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);

    // Long receiver hold-off while the sender keeps offering.
    hold_long = 1'b1;
    for (int i = 0; i < 40; i++) send_random();

    for (int i = 0; i < N_RANDOM; i++) send_random();
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    settle = 0;
    while (settle < 20) begin
      @(posedge clk);
      settle++;
    end

    $display("Sent %0d queries: %0d inside, %0d on, %0d outside, %0d degenerate.",
             sent, verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
